@@ sv/srle_pkg.sv @@
// Shared types, codes and the nibble grammar step for the 4-bit pixel RLE decoder.
// No dependencies; compiled first.
package srle_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [9:0]  LINE_WIDTH_RESET = 10'd720;
    localparam logic [10:0] LINE_MAX         = 11'd2047;
    localparam logic [7:0]  TYPE_4BIT        = 8'h11;
    localparam logic [7:0]  TYPE_EOL         = 8'hF0;
    localparam logic [3:0]  RUN_PV_HIGH      = 4'hF;

    // Result kinds, also used as operation codes in the queue.
    localparam logic [1:0] KIND_RUN   = 2'd0;
    localparam logic [1:0] KIND_EOS   = 2'd1;
    localparam logic [1:0] KIND_EOL   = 2'd2;
    localparam logic [1:0] KIND_UNSUP = 2'd3;

    // Grammar phases.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_ESC   = 3'd1;
    localparam logic [2:0] PH_COLOR = 3'd2;
    localparam logic [2:0] PH_EXT   = 3'd3;
    localparam logic [2:0] PH_HI    = 3'd4;
    localparam logic [2:0] PH_LO    = 3'd5;
    localparam logic [2:0] PH_LONG  = 3'd6;

    localparam logic [3:0] NIB_ONE0 = 4'hC;
    localparam logic [3:0] NIB_TWO0 = 4'hD;
    localparam logic [3:0] NIB_EXT  = 4'hE;
    localparam logic [8:0] EXT_BIAS  = 9'd9;
    localparam logic [8:0] LONG_BIAS = 9'd25;
    localparam logic [8:0] MID_BIAS  = 9'd4;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
        logic [8:0] len;
        logic [7:0] pv;
    } srle_op_t;

    typedef struct packed {
        logic     fs;
        logic     bottom;
        srle_op_t op0;
        srle_op_t op1;
    } srle_entry_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] plen;
        logic       run;
        logic       eos;
        logic [8:0] len;
        logic [3:0] col;
    } srle_nib_t;

    function automatic srle_nib_t nib_step(input logic [2:0] phase, input logic [7:0] plen,
                                           input logic [3:0] v);
        srle_nib_t r;
        r.phase = PH_START;
        r.plen  = plen;
        r.run   = 1'b0;
        r.eos   = 1'b0;
        r.len   = 9'd0;
        r.col   = v;
        unique case (phase)
            PH_ESC:
            begin
                r.col = 4'd0;
                if (v == 4'd0) begin
                    r.eos = 1'b1;
                end else if (v == NIB_ONE0) begin
                    r.run = 1'b1;
                    r.len = 9'd1;
                end else if (v == NIB_TWO0) begin
                    r.run = 1'b1;
                    r.len = 9'd2;
                end else if (v[3] == 1'b0) begin
                    r.run = 1'b1;
                    r.len = {5'd0, v} + 9'd2;
                end else if (v[2] == 1'b0) begin
                    r.plen  = {6'd0, v[1:0]} + MID_BIAS[7:0];
                    r.phase = PH_COLOR;
                end else if (v == NIB_EXT) begin
                    r.phase = PH_EXT;
                end else begin
                    r.phase = PH_HI;
                end
            end
            PH_COLOR:
            begin
                r.run = 1'b1;
                r.len = {1'b0, plen};
            end
            PH_EXT:
            begin
                r.plen  = {4'd0, v} + EXT_BIAS[7:0];
                r.phase = PH_COLOR;
            end
            PH_HI:
            begin
                r.plen  = {v, 4'd0};
                r.phase = PH_LO;
            end
            PH_LO:
            begin
                r.plen  = plen | {4'd0, v};
                r.phase = PH_LONG;
            end
            PH_LONG:
            begin
                r.run = 1'b1;
                r.len = {1'b0, plen} + LONG_BIAS;
            end
            default:
            begin
                // start phase; unused code 7 acts the same
                if (v != 4'd0) begin
                    r.run = 1'b1;
                    r.len = 9'd1;
                end else begin
                    r.phase = PH_ESC;
                end
            end
        endcase
        return r;
    endfunction

    function automatic srle_op_t nib_op(input srle_nib_t n);
        srle_op_t o;
        o.valid = n.run | n.eos;
        o.code  = n.eos ? KIND_EOS : KIND_RUN;
        o.len   = n.len;
        o.pv    = n.eos ? 8'd0 : {RUN_PV_HIGH, n.col};
        return o;
    endfunction

endpackage

@@ sv/srle_fifo.sv @@
// Small register queue between the front and back parts.
// Generic payload vector; no package dependencies.
module srle_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

@@ sv/srle_front.sv @@
// Front part: takes input bytes, runs the data-type / nibble grammar and
// turns each byte into a queue entry of up to two operations. Uses srle_pkg.
module srle_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 field_start,
    input  logic                 bottom_field,
    input  logic                 queue_full,
    output logic                 push,
    output srle_pkg::srle_entry_t entry
);
    import srle_pkg::*;

    logic       in_string_reg, in_string_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] plen_reg, plen_next;
    logic       is_base;
    logic [2:0] ph_base;
    logic [7:0] pl_base;
    srle_nib_t  hi_res, lo_res;
    srle_op_t   hi_op, lo_op;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // field start clears the grammar before the byte is looked at
    assign is_base = field_start ? 1'b0 : in_string_reg;
    assign ph_base = field_start ? PH_START : phase_reg;
    assign pl_base = field_start ? 8'd0 : plen_reg;

    assign hi_res = nib_step(ph_base, pl_base, data_byte[7:4]);
    assign lo_res = nib_step(hi_res.phase, hi_res.plen, data_byte[3:0]);
    assign hi_op  = nib_op(hi_res);
    assign lo_op  = nib_op(lo_res);

    always_comb
    begin
        in_string_next = is_base;
        phase_next     = ph_base;
        plen_next      = pl_base;
        entry.fs       = field_start;
        entry.bottom   = bottom_field;
        entry.op0      = '0;
        entry.op1      = '0;
        if (!is_base) begin
            if (data_byte == TYPE_4BIT) begin
                in_string_next = 1'b1;
                phase_next     = PH_START;
            end else if (data_byte == TYPE_EOL) begin
                entry.op0.valid = 1'b1;
                entry.op0.code  = KIND_EOL;
            end else begin
                entry.op0.valid = 1'b1;
                entry.op0.code  = KIND_UNSUP;
                entry.op0.pv    = data_byte;
            end
        end else if (hi_res.eos) begin
            // low nibble is padding
            entry.op0      = hi_op;
            in_string_next = 1'b0;
            phase_next     = hi_res.phase;
            plen_next      = hi_res.plen;
        end else begin
            if (hi_op.valid) begin
                entry.op0 = hi_op;
                entry.op1 = lo_op;
            end else begin
                entry.op0 = lo_op;
            end
            in_string_next = !lo_res.eos;
            phase_next     = lo_res.phase;
            plen_next      = lo_res.plen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_string_reg <= 1'b0;
            phase_reg     <= PH_START;
            plen_reg      <= 8'd0;
        end else if (push) begin
            in_string_reg <= in_string_next;
            phase_reg     <= phase_next;
            plen_reg      <= plen_next;
        end
    end

    a_op_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (push && entry.op1.valid) |-> entry.op0.valid)
        else $error("second op without first");

endmodule

@@ sv/srle_back.sv @@
// Back part: executes queued operations against x position and line count,
// clips runs at the line width and drives the output register. Uses srle_pkg.
module srle_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [9:0]            cfg_write_data,
    input  logic                  head_valid,
    input  srle_pkg::srle_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [7:0]            pixel_value,
    output logic [9:0]            x_start,
    output logic [8:0]            run_length,
    output logic [10:0]           line_number
);
    import srle_pkg::*;

    logic [9:0]  line_width_reg;
    logic [9:0]  lp_reg, lp_next;
    logic [10:0] cl_reg, cl_next;
    logic        sel_reg, sel_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  pv_reg, pv_next;
    logic [9:0]  xs_reg, xs_next;
    logic [8:0]  rl_reg, rl_next;
    logic [10:0] ln_reg, ln_next;
    logic        step, apply_fs;
    logic [9:0]  lp_base, room;
    logic [10:0] cl_base;
    logic [11:0] cl_plus2;
    logic [8:0]  take;
    srle_op_t    op;

    assign step     = head_valid && (!out_valid_reg || out_ready);
    assign apply_fs = !sel_reg && head.fs;
    assign lp_base  = apply_fs ? 10'd0 : lp_reg;
    assign cl_base  = apply_fs ? {10'd0, head.bottom} : cl_reg;
    assign op       = sel_reg ? head.op1 : head.op0;
    assign room     = line_width_reg - lp_base;
    assign take     = ({1'b0, op.len} < room) ? op.len : room[8:0];
    assign cl_plus2 = {1'b0, cl_base} + 12'd2;

    always_comb
    begin
        lp_next        = lp_reg;
        cl_next        = cl_reg;
        sel_next       = sel_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        pv_next        = pv_reg;
        xs_next        = xs_reg;
        rl_next        = rl_reg;
        ln_next        = ln_reg;
        if (step) begin
            lp_next = lp_base;
            cl_next = cl_base;
            if (op.valid) begin
                kind_next = op.code;
                pv_next   = op.pv;
                xs_next   = lp_base;
                rl_next   = 9'd0;
                ln_next   = cl_base;
                unique case (op.code)
                    KIND_RUN:
                    begin
                        // run starting at or past the width is dropped
                        if (lp_base < line_width_reg) begin
                            out_valid_next = 1'b1;
                            rl_next        = take;
                            lp_next        = lp_base + {1'b0, take};
                        end
                    end
                    KIND_EOS:
                    begin
                        out_valid_next = 1'b1;
                    end
                    KIND_EOL:
                    begin
                        out_valid_next = 1'b1;
                        lp_next        = 10'd0;
                        cl_next        = (cl_plus2 > {1'b0, LINE_MAX}) ? LINE_MAX
                                                                       : cl_plus2[10:0];
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                        xs_next        = 10'd0;
                    end
                endcase
            end
            if (!sel_reg && head.op1.valid) begin
                sel_next = 1'b1;
            end else begin
                sel_next = 1'b0;
                pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_width_reg <= LINE_WIDTH_RESET;
            lp_reg         <= 10'd0;
            cl_reg         <= 11'd0;
            sel_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_write_en) begin
                line_width_reg <= cfg_write_data;
            end
            lp_reg        <= lp_next;
            cl_reg        <= cl_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        pv_reg   <= pv_next;
        xs_reg   <= xs_next;
        rl_reg   <= rl_next;
        ln_reg   <= ln_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign pixel_value = pv_reg;
    assign x_start     = xs_reg;
    assign run_length  = rl_reg;
    assign line_number = ln_reg;

    a_sel_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> head_valid)
        else $error("second op selected with empty queue");
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_RUN) |-> (rl_reg != 9'd0))
        else $error("empty run delivered");
    a_other_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_RUN) |-> (rl_reg == 9'd0))
        else $error("non-run result with a length");

endmodule

@@ sv/subtitle_4bit_pixel_rle_decoder.sv @@
// Each result passes through the queue and then the output register after its byte's transfer.
// One byte per cycle while the queue has room; a byte with two results holds the back
// part for both (one output register, one result per unstalled cycle), so the queue fills.
// Reset (rst_n, async, active low): idle grammar, x 0, line 0, line width 720, queue empty.
// Top level: front (grammar) -> queue -> back (clipping, x/line tracking, output register).
module subtitle_4bit_pixel_rle_decoder #(
    parameter int QUEUE_DEPTH = srle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        field_start,
    input  logic        bottom_field,
    // line width register write
    input  logic        cfg_write_en,
    input  logic [9:0]  cfg_write_data,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  pixel_value,
    output logic [9:0]  x_start,
    output logic [8:0]  run_length,
    output logic [10:0] line_number
);
    import srle_pkg::*;

    localparam int ENTRY_W = $bits(srle_entry_t);

    srle_entry_t      push_entry;
    srle_entry_t      head_entry;
    logic [ENTRY_W-1:0] head_bits;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             head_valid;

    // Front: one transfer per cycle while the queue has room. Each byte becomes
    // one entry (data type, or both nibbles decoded), possibly with no operation.
    srle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .field_start  (field_start),
        .bottom_field (bottom_field),
        .queue_full   (queue_full),
        .push         (push),
        .entry        (push_entry)
    );

    // Queue decouples the grammar from output stalls.
    srle_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_bits)
    );

    assign head_entry = srle_entry_t'(head_bits);

    // Back: one op per unstalled cycle, clipped at the line width, into the output register.
    srle_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .head_valid     (head_valid),
        .head           (head_entry),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .pixel_value    (pixel_value),
        .x_start        (x_start),
        .run_length     (run_length),
        .line_number    (line_number)
    );

endmodule
